### rtl/core/assert_macros.svh
// Assertion macros shared by the PFC current loop RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds in the same cycle as cond.
`define ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("pfc current loop check failed");

// Check that prop holds in the cycle after cond.
`define ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("pfc current loop check failed");

`endif

### rtl/core/pcpl_pkg.sv
// Types, constants and microprogram ROM of the PFC current PID loop.
`timescale 1ns / 1ps
`default_nettype none

package pcpl_pkg;

  // Duty clamp and datapath widths
  localparam int unsigned DUTY_MAX = 2000;
  localparam int STEP_W = 5;
  localparam int A_W    = 33;
  localparam int B_W    = 24;
  localparam int P_W    = A_W + B_W;
  localparam int ACC_W  = 48;

  localparam logic [ACC_W-1:0] DUTY_LIMIT = ACC_W'(DUTY_MAX) << 16;
  localparam logic [10:0]      DUTY_CLAMP = 11'(DUTY_MAX);

  // Scale factors, divisors and reciprocals (floor of 2^k / divisor)
  localparam logic [B_W-1:0] K_VSCALE = 24'd96000;
  localparam logic [B_W-1:0] K_ISCALE = 24'd320000;
  localparam logic [B_W-1:0] DIV_V    = 24'd1023;
  localparam logic [B_W-1:0] DIV_I    = 24'd33759;
  localparam logic [B_W-1:0] RECIP_V  = 24'd4198404;  // 2^32 / 1023
  localparam logic [B_W-1:0] RECIP_I  = 24'd127224;   // 2^32 / 33759
  localparam logic [B_W-1:0] RECIP_R  = 24'd671088;   // 2^24 / 25
  localparam logic [16:0]    DIV_R    = 17'd25;
  localparam logic [26:0]    RND_V    = 27'd511;
  localparam logic [28:0]    RND_I    = 29'd16879;

  // Register map
  typedef enum logic [1:0] {
    REG_PROP  = 2'd0,
    REG_INTEG = 2'd1,
    REG_DERIV = 2'd2
  } reg_idx_t;

  // Multiplier operand A source
  typedef enum logic [3:0] {
    A_NONE, A_AV, A_AI, A_M1, A_M2, A_QV, A_QI, A_Y, A_ERR, A_DIFF, A_SUM
  } a_sel_t;

  // Multiplier operand B source
  typedef enum logic [3:0] {
    B_VSCALE, B_ISCALE, B_RECV, B_RECI, B_DIVV, B_DIVI, B_RECR, B_KP, B_KI, B_KD
  } b_sel_t;

  // Writeback of the previous step's product or of other datapath results
  typedef enum logic [3:0] {
    W_NONE, W_M1, W_M2, W_QV, W_QI, W_FIXV, W_FIXI, W_QR, W_FIXR,
    W_ERR, W_STATE, W_ACC_LOAD, W_ACC_ADD, W_DUTY
  } wb_t;

  // Jump condition
  typedef enum logic [1:0] {
    J_NEVER, J_ALWAYS, J_NO_INPUT, J_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic              take;
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    wb_t               wb;
    cond_t             cond;
    logic [STEP_W-1:0] addr;
  } ucode_t;

  localparam logic [STEP_W-1:0] UC_IDLE = 5'd0;
  localparam logic [STEP_W-1:0] UC_DUTY = 5'd16;

  // Fold a raw sample: |1023 - 2*s|
  function automatic logic [9:0] fold_sample(input logic [9:0] s);
    logic [10:0] twice;
    twice = {s, 1'b0};
    if (s[9]) begin
      fold_sample = 10'(twice - 11'd1023);
    end else begin
      fold_sample = 10'(11'd1023 - twice);
    end
  endfunction

  // Microprogram: one control word per step
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w.take  = 1'b0;
    w.a_sel = A_NONE;
    w.b_sel = B_KP;
    w.wb    = W_NONE;
    w.cond  = J_NEVER;
    w.addr  = UC_IDLE;
    unique case (step)
      5'd0: begin
        w.take = 1'b1; w.cond = J_NO_INPUT; w.addr = UC_IDLE;
      end
      5'd1: begin
        w.a_sel = A_AV; w.b_sel = B_VSCALE;
      end
      5'd2: begin
        w.a_sel = A_AI; w.b_sel = B_ISCALE; w.wb = W_M1;
      end
      5'd3: begin
        w.a_sel = A_M1; w.b_sel = B_RECV; w.wb = W_M2;
      end
      5'd4: begin
        w.a_sel = A_M2; w.b_sel = B_RECI; w.wb = W_QV;
      end
      5'd5: begin
        w.a_sel = A_QV; w.b_sel = B_DIVV; w.wb = W_QI;
      end
      5'd6: begin
        w.a_sel = A_QI; w.b_sel = B_DIVI; w.wb = W_FIXV;
      end
      5'd7: begin
        w.wb = W_FIXI;
      end
      5'd8: begin
        w.a_sel = A_Y; w.b_sel = B_RECR;
      end
      5'd9: begin
        w.wb = W_QR;
      end
      5'd10: begin
        w.wb = W_FIXR;
      end
      5'd11: begin
        w.wb = W_ERR;
      end
      5'd12: begin
        w.a_sel = A_ERR; w.b_sel = B_KP; w.wb = W_STATE;
      end
      5'd13: begin
        w.a_sel = A_DIFF; w.b_sel = B_KD; w.wb = W_ACC_LOAD;
      end
      5'd14: begin
        w.a_sel = A_SUM; w.b_sel = B_KI; w.wb = W_ACC_ADD;
      end
      5'd15: begin
        w.wb = W_ACC_ADD;
      end
      5'd16: begin
        w.wb = W_DUTY; w.cond = J_OUT_BUSY; w.addr = UC_DUTY;
      end
      default: begin
        w.cond = J_ALWAYS; w.addr = UC_IDLE;
      end
    endcase
    ucode_rom = w;
  endfunction

endpackage

`default_nettype wire

### rtl/core/pfc_current_pid_loop.sv
// PFC current PID loop: microcoded sequencer around one shared 33x24 multiplier.
// m_tvalid rises when the duty step loads the output register.
// Input is taken only at the idle step, after the previous item has run its course.
// A result held in the output register stalls the sequencer only at its duty step.
// Reset clears the gains, last error, error sum, step counter and output valid.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pfc_current_pid_loop
  import pcpl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // voltage_sample[9:0], current_sample[19:10]
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata    // duty_count[10:0], bus_voltage[27:11],
                                      // phase_current[41:28]
);

  // Gains and loop state
  logic signed [15:0] prop_gain;
  logic signed [15:0] integ_gain;
  logic signed [15:0] deriv_gain;
  logic signed [15:0] last_error;
  logic signed [31:0] error_sum;

  // Sequencer
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ucode_t            uc;
  logic              taken;

  // Datapath registers
  logic [9:0]              av;
  logic [9:0]              ai;
  logic [26:0]             m1;
  logic [28:0]             m2;
  logic [16:0]             qv;
  logic [13:0]             qi;
  logic [16:0]             y;
  logic [12:0]             qr;
  logic signed [15:0]      err;
  logic signed [16:0]      diff;
  logic signed [ACC_W-1:0] acc;
  logic signed [P_W-1:0]   prod;

  // Multiplier
  logic signed [A_W-1:0] mul_a;
  logic signed [B_W-1:0] mul_b;
  logic signed [P_W-1:0] mul_p;

  // Output register
  logic [10:0] out_duty;
  logic [16:0] out_volts;
  logic [13:0] out_amps;
  logic        out_busy;
  logic        out_load;

  // Writeback helpers
  logic [27:0]        r_v;
  logic [29:0]        r_i;
  logic [16:0]        r_r;
  logic [19:0]        y_calc;
  logic signed [15:0] err_calc;
  logic signed [16:0] diff_calc;
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_sat;
  logic [10:0]        duty_calc;
  logic               cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      REG_PROP:  prdata = 32'(prop_gain);
      REG_INTEG: prdata = 32'(integ_gain);
      REG_DERIV: prdata = 32'(deriv_gain);
      default:   prdata = 32'd0;
    endcase
  end

  // Fetch the control word and pick the next step; hold off input during reset
  assign uc       = ucode_rom(step);
  assign out_busy = m_tvalid && !m_tready;
  assign s_tready = uc.take && !rst;

  always_comb begin
    unique case (uc.cond)
      J_NEVER:    taken = 1'b0;
      J_ALWAYS:   taken = 1'b1;
      J_NO_INPUT: taken = !s_tvalid;
      J_OUT_BUSY: taken = out_busy;
    endcase
    step_next = taken ? uc.addr : step + 1'b1;
  end

  // Operand selection
  always_comb begin
    case (uc.a_sel)
      A_AV:    mul_a = A_W'(av);
      A_AI:    mul_a = A_W'(ai);
      A_M1:    mul_a = A_W'(m1);
      A_M2:    mul_a = A_W'(m2);
      A_QV:    mul_a = A_W'(qv);
      A_QI:    mul_a = A_W'(qi);
      A_Y:     mul_a = A_W'(y);
      A_ERR:   mul_a = A_W'(err);
      A_DIFF:  mul_a = A_W'(diff);
      A_SUM:   mul_a = A_W'(error_sum);
      default: mul_a = '0;
    endcase
    case (uc.b_sel)
      B_VSCALE: mul_b = $signed(K_VSCALE);
      B_ISCALE: mul_b = $signed(K_ISCALE);
      B_RECV:   mul_b = $signed(RECIP_V);
      B_RECI:   mul_b = $signed(RECIP_I);
      B_DIVV:   mul_b = $signed(DIV_V);
      B_DIVI:   mul_b = $signed(DIV_I);
      B_RECR:   mul_b = $signed(RECIP_R);
      B_KP:     mul_b = B_W'(prop_gain);
      B_KI:     mul_b = B_W'(integ_gain);
      B_KD:     mul_b = B_W'(deriv_gain);
      default:  mul_b = '0;
    endcase
  end

  assign mul_p = P_W'(mul_a) * P_W'(mul_b);

  // Quotient corrections, reference, error, sum and duty clamp arithmetic
  always_comb begin
    r_v       = 28'(m1) - prod[27:0];
    r_i       = 30'(m2) - prod[29:0];
    r_r       = y - 17'(17'(qr) * DIV_R);
    y_calc    = 20'(qv) * 20'd9 + 20'd100;
    err_calc  = $signed({3'b000, qr}) - $signed({2'b00, qi});
    diff_calc = 17'(err) - 17'(last_error);
    sum_wide  = 33'(error_sum) + 33'(err);
    if (sum_wide[32] != sum_wide[31]) begin
      sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sum_sat = sum_wide[31:0];
    end
    if (acc >= $signed(DUTY_LIMIT)) begin
      duty_calc = DUTY_CLAMP;
    end else if (acc <= 0) begin
      duty_calc = 11'd0;
    end else begin
      duty_calc = acc[26:16];
    end
  end

  assign out_load = (uc.wb == W_DUTY) && !out_busy;

  // Datapath registers and writeback
  always_ff @(posedge clk) begin
    if (uc.take && s_tvalid) begin
      av <= fold_sample(s_tdata[9:0]);
      ai <= fold_sample(s_tdata[19:10]);
    end
    if (uc.a_sel != A_NONE) begin
      prod <= mul_p;
    end
    case (uc.wb)
      W_M1:       m1 <= prod[26:0] + RND_V;
      W_M2:       m2 <= prod[28:0] + RND_I;
      W_QV:       qv <= prod[48:32];
      W_QI:       qi <= prod[45:32];
      W_FIXV: begin
        if (r_v >= 28'(DIV_V)) qv <= qv + 1'b1;
      end
      W_FIXI: begin
        if (r_i >= 30'(DIV_I)) qi <= qi + 1'b1;
        y <= y_calc[19:3];
      end
      W_QR:       qr <= prod[36:24];
      W_FIXR: begin
        if (r_r >= DIV_R) qr <= qr + 1'b1;
      end
      W_ERR:      err <= err_calc;
      W_STATE:    diff <= diff_calc;
      W_ACC_LOAD: acc <= prod[ACC_W-1:0];
      W_ACC_ADD:  acc <= acc + prod[ACC_W-1:0];
      default: ;
    endcase
    if (out_load) begin
      out_duty  <= duty_calc;
      out_volts <= qv;
      out_amps  <= qi;
    end
  end

  // Control state, gains and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= UC_IDLE;
      m_tvalid   <= 1'b0;
      prop_gain  <= '0;
      integ_gain <= '0;
      deriv_gain <= '0;
      last_error <= '0;
      error_sum  <= '0;
    end else begin
      step <= step_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (uc.wb == W_STATE) begin
        last_error <= err;
        error_sum  <= sum_sat;
      end
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_PROP:  prop_gain  <= pwdata[15:0];
          REG_INTEG: integ_gain <= pwdata[15:0];
          REG_DERIV: deriv_gain <= pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  assign m_tdata = {6'b000000, out_amps, out_volts, out_duty};

  // Sequencer and datapath checks
  `ASSERT_NXT(a_accept_starts, s_tvalid && s_tready, step == 5'd1)
  `ASSERT_IMP(a_valid_from_duty, $rose(m_tvalid), $past(uc.wb) == W_DUTY)
  `ASSERT_IMP(a_fixv_range, uc.wb == W_FIXV, r_v < 28'(DIV_V) * 28'd2)
  `ASSERT_IMP(a_duty_bound, m_tvalid, out_duty <= DUTY_CLAMP)

endmodule

`default_nettype wire

### sim/testbench.sv
// Testbench for the PFC current PID loop: directed and random control ticks against a predictor.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import pcpl_pkg::*;

  // Result fields, duty count in the low bits as on m_tdata
  typedef struct packed {
    logic [13:0] amps;
    logic [16:0] volts;
    logic [10:0] duty;
  } tick_result_t;

  localparam int IDLE_PCT     = 22;
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_TICKS = 1300;
  localparam int PHASES       = 8;

  // Register byte addresses
  localparam logic [3:0] ADDR_PROP  = {REG_PROP, 2'b00};
  localparam logic [3:0] ADDR_INTEG = {REG_INTEG, 2'b00};
  localparam logic [3:0] ADDR_DERIV = {REG_DERIV, 2'b00};
  localparam logic [3:0] ADDR_SPARE = 4'd12;

  localparam logic signed [15:0] GAIN_MIN = 16'sh8000;
  localparam logic signed [15:0] GAIN_MAX = 16'sh7FFF;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  wire  [31:0] prdata;
  wire         pready;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [23:0] s_tdata  = '0;   // voltage_sample[9:0], current_sample[19:10]
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [47:0] m_tdata;         // duty_count[10:0], bus_voltage[27:11], phase_current[41:28]

  // Loop state and gains as the block should hold them
  logic signed [15:0] gain_p = '0;
  logic signed [15:0] gain_i = '0;
  logic signed [15:0] gain_d = '0;
  int                 prev_error  = 0;
  int                 error_total = 0;

  tick_result_t pending_results[$];
  int           mismatch_count = 0;
  bit           steady = 1'b0;

  pfc_current_pid_loop u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Run one control tick: scale, reference, error, PID, clamp
  function automatic tick_result_t predict_tick(input logic [9:0] vs, input logic [9:0] cs);
    longint av, ai, volts, amps, iref, err, diff, total, ctrl;
    tick_result_t r;
    av = 2 * longint'(vs) - 1023;
    if (av < 0) av = -av;
    ai = 2 * longint'(cs) - 1023;
    if (ai < 0) ai = -ai;
    volts = (2 * 96000 * av + 1023) / 2046;
    amps  = (2 * 320000 * ai + 33759) / 67518;
    iref  = (9 * volts + 100) / 200;
    err   = iref - amps;
    diff  = err - prev_error;
    total = error_total + err;
    // saturate the running sum to 32 bits
    if (total > 64'sd2147483647) total = 64'sd2147483647;
    if (total < -64'sd2147483648) total = -64'sd2147483648;
    error_total = int'(total);
    prev_error  = int'(err);
    ctrl = longint'(gain_p) * err + longint'(gain_d) * diff + longint'(gain_i) * total;
    if (ctrl >= longint'(DUTY_MAX) * 65536) begin
      r.duty = 11'(DUTY_MAX);
    end else if (ctrl <= 0) begin
      r.duty = '0;
    end else begin
      r.duty = 11'(ctrl >>> 16);
    end
    r.volts = 17'(volts);
    r.amps  = 14'(amps);
    return r;
  endfunction

  // Sample mix: mostly uniform, some fold extremes, some near mid-scale
  function automatic logic [9:0] pick_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return 10'($urandom);
    if (pick < 85) begin
      case ($urandom_range(3))
        0: return 10'd0;
        1: return 10'd1023;
        2: return 10'd511;
        default: return 10'd512;
      endcase
    end
    return 10'($urandom_range(540, 484));
  endfunction

  // Receiver: drop tready at random unless in a steady stretch
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    tick_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = tick_result_t'(m_tdata[41:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, actual duty %0d volts %0d amps %0d",
                 $time, got.duty, got.volts, got.amps);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.duty !== want.duty) begin
          $display("%0t: duty_count expected %0d actual %0d", $time, want.duty, got.duty);
          mismatch_count++;
        end
        if (got.volts !== want.volts) begin
          $display("%0t: bus_voltage expected %0d actual %0d", $time, want.volts, got.volts);
          mismatch_count++;
        end
        if (got.amps !== want.amps) begin
          $display("%0t: phase_current expected %0d actual %0d", $time, want.amps, got.amps);
          mismatch_count++;
        end
      end
    end
  end

  // Send one sample beat, idling first at random
  task automatic send_tick(input logic [9:0] vs, input logic [9:0] cs);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, cs, vs};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_tick(vs, cs));
  endtask

  // Hold the sender until every expected result has come back
  task automatic wait_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Let the block go idle before touching the registers
  task automatic wait_idle();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    // only the low 16 bits count; unmapped addresses are ignored
    case (addr)
      ADDR_PROP:  gain_p = data[15:0];
      ADDR_INTEG: gain_i = data[15:0];
      ADDR_DERIV: gain_d = data[15:0];
      default: ;
    endcase
  endtask

  // Write all three gains with junk in the unused upper bits
  task automatic set_gains(input logic [15:0] kp, input logic [15:0] ki, input logic [15:0] kd);
    write_reg(ADDR_PROP,  {16'($urandom), kp});
    write_reg(ADDR_INTEG, {16'($urandom), ki});
    write_reg(ADDR_DERIV, {16'($urandom), kd});
  endtask

  // Zero gains after reset: only the scaling shows, duty stays at zero
  task automatic test_scaling();
    send_tick(10'd0, 10'd0);
    send_tick(10'd1023, 10'd1023);
    send_tick(10'd511, 10'd512);
    send_tick(10'd512, 10'd511);
    send_tick(10'd0, 10'd511);
    send_tick(10'd1023, 10'd512);
    send_tick(10'h2AA, 10'h155);
    send_tick(10'h155, 10'h2AA);
    wait_idle();
  endtask

  // Unmapped address must not alias a gain; upper data bits are dropped
  task automatic test_register_map();
    write_reg(ADDR_SPARE, 32'h0000_4000);
    send_tick(10'd0, 10'd512);
    wait_idle();
    write_reg(ADDR_PROP, 32'hA5A5_0100);
    send_tick(10'd1023, 10'd511);
    send_tick(10'd300, 10'd700);
    wait_idle();
    write_reg(ADDR_DERIV, 32'h5A5A_FF00);
    write_reg(ADDR_INTEG, 32'hFFFF_0001);
    send_tick(10'd0, 10'd200);
    send_tick(10'd1023, 10'd512);
    wait_idle();
  endtask

  // Upper clamp, lower clamp, mid-range and sub-count drive
  task automatic test_clamps();
    set_gains(GAIN_MAX, 16'd0, 16'd0);
    send_tick(10'd0, 10'd511);
    send_tick(10'd511, 10'd0);
    wait_idle();
    set_gains(GAIN_MIN, 16'd0, 16'd0);
    send_tick(10'd511, 10'd0);
    send_tick(10'd1023, 10'd512);
    wait_idle();
    set_gains(16'd15000, 16'd0, 16'd0);
    send_tick(10'd1023, 10'd511);
    wait_idle();
    set_gains(16'd1, 16'd0, 16'd0);
    send_tick(10'd0, 10'd512);
    wait_idle();
    set_gains(16'd0, 16'd0, GAIN_MIN);
    send_tick(10'd0, 10'd0);
    send_tick(10'd0, 10'd511);
    wait_idle();
    set_gains(16'd0, GAIN_MIN, 16'd0);
    send_tick(10'd511, 10'd1023);
    wait_idle();
  endtask

  // Random gains per phase, extremes first; one steady phase, one drained phase
  task automatic test_random();
    int          per_phase;
    logic [15:0] g[3];
    per_phase = RANDOM_TICKS / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      for (int k = 0; k < 3; k++) begin
        if (ph == 0) begin
          g[k] = GAIN_MIN;
        end else if (ph == 1) begin
          g[k] = GAIN_MAX;
        end else begin
          case ($urandom_range(3))
            0: g[k] = $urandom_range(1) ? GAIN_MAX : GAIN_MIN;
            1: g[k] = 16'($signed(11'($urandom_range(1023, 0) - 512)));
            2: g[k] = 16'($urandom);
            default: g[k] = '0;
          endcase
        end
      end
      set_gains(g[0], g[1], g[2]);
      steady = (ph == 3);
      for (int n = 0; n < per_phase; n++) begin
        send_tick(pick_sample(), pick_sample());
        // drain the pipe now and then
        if (ph == 5 && n % 40 == 39) wait_results();
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_scaling();
    test_register_map();
    test_clamps();
    test_random();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
